>>> hdl/wpkeg_pkg.sv
`timescale 1ns / 1ps

package wpkeg_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 16;
    localparam int unsigned TIMEOUT_W       = 16;
    localparam int unsigned MARKER_W        = 8;
    localparam int unsigned CFG_DATA_W      = 16;
    localparam int unsigned CFG_IDX_W       = 1;
    localparam int unsigned BTN_W           = 10;
    localparam int unsigned NUM_EV          = 11;
    localparam int unsigned KEY_W           = 4;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd334;
    localparam logic [MARKER_W-1:0]  MARKER_RST  = 8'hBF;
    localparam logic [BTN_W-1:0]     CHORD_MASK  = 10'h3C3;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER  = 1'b1;

    // button bit of each key in event order A, B, L, R, start, select, up, down, left, right
    localparam logic [3:0] KEY_BIT [BTN_W] = '{
        4'd0, 4'd1, 4'd8, 4'd9, 4'd7, 4'd6, 4'd4, 4'd5, 4'd3, 4'd2
    };

    typedef enum logic [1:0] {
        LINK_UNKNOWN   = 2'd0,
        LINK_SEARCHING = 2'd1,
        LINK_TEN       = 2'd2,
        LINK_EIGHT     = 2'd3
    } t_link;

    typedef enum logic {
        SCAN_IDLE = 1'b0,
        SCAN_RUN  = 1'b1
    } t_scan;

    typedef struct packed {
        logic             en;
        logic [BTN_W-1:0] data;
    } t_apply;

endpackage

>>> hdl/wpkeg_poll_if.sv
`timescale 1ns / 1ps

interface wpkeg_poll_if;
    logic       valid;
    logic       ready;
    logic       payload_ready;
    logic [7:0] first_byte;
    logic [7:0] second_byte;

    modport source (output valid, output payload_ready, output first_byte,
                    output second_byte, input ready);
    modport sink   (input valid, input payload_ready, input first_byte,
                    input second_byte, output ready);
endinterface

>>> hdl/wpkeg_event_if.sv
`timescale 1ns / 1ps

interface wpkeg_event_if;
    logic       valid;
    logic       ready;
    logic [3:0] key;
    logic       pressed;
    logic       last;

    modport source (output valid, output key, output pressed, output last, input ready);
    modport sink   (input valid, input key, input pressed, input last, output ready);
endinterface

>>> hdl/wpkeg_link.sv
`timescale 1ns / 1ps

module wpkeg_link
    import wpkeg_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic                  i_payload_ready,
    input  logic [7:0]            i_first_byte,
    input  logic [7:0]            i_second_byte,
    output t_apply                o_apply
);

    localparam int unsigned CMP_W = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;

    logic [TIMEOUT_W-1:0]   r_timeout;
    logic [MARKER_W-1:0]    r_marker;
    t_link                  r_link, n_link;
    logic [COUNT_WIDTH-1:0] r_idle, n_idle;

    logic [COUNT_WIDTH-1:0] idle_mid;
    logic                   rdy;
    logic                   lost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_marker  <= MARKER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT: r_timeout <= i_cfg_data[TIMEOUT_W-1:0];
                CFG_MARKER:  r_marker  <= i_cfg_data[MARKER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= LINK_UNKNOWN;
            r_idle <= '0;
        end else if (i_accept) begin
            r_link <= n_link;
            r_idle <= n_idle;
        end
    end

    always_comb begin
        n_link   = (r_link == LINK_UNKNOWN) ? LINK_SEARCHING : r_link;
        idle_mid = r_idle;
        rdy      = i_payload_ready;
        o_apply  = '{en: 1'b0, data: '0};
        lost     = 1'b0;

        if (n_link == LINK_SEARCHING && rdy) begin
            idle_mid = '0;
            n_link   = (i_second_byte == r_marker) ? LINK_EIGHT : LINK_TEN;
            rdy      = 1'b0;
        end

        if (n_link == LINK_TEN || n_link == LINK_EIGHT) begin
            lost = CMP_W'(idle_mid) >= CMP_W'(r_timeout);
            if (lost) begin
                n_link = LINK_UNKNOWN;
            end else if (rdy) begin
                idle_mid   = '0;
                o_apply.en = 1'b1;
                if (n_link == LINK_TEN) begin
                    o_apply.data = {i_first_byte[1:0], i_second_byte};
                end else begin
                    o_apply.data = {2'b00, i_first_byte};
                end
            end
        end else begin
            o_apply.en = 1'b1;
        end

        n_idle = (idle_mid != '1) ? idle_mid + 1'b1 : idle_mid;
    end

endmodule

>>> hdl/wpkeg_scan.sv
`timescale 1ns / 1ps

module wpkeg_scan
    import wpkeg_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_apply        i_apply,
    output logic          o_busy,
    wpkeg_event_if.source o_event
);

    t_scan             r_state, n_state;
    logic [BTN_W-1:0]  r_bits;
    logic [NUM_EV-1:0] r_pend, n_pend;
    logic [NUM_EV-1:0] r_press;
    logic [KEY_W-1:0]  r_idx, n_idx;
    logic              r_ov, n_ov;
    logic [KEY_W-1:0]  r_key;
    logic              r_pressed;
    logic              r_last;

    logic [BTN_W-1:0]  diff;
    logic [NUM_EV-1:0] ld_pend;
    logic [NUM_EV-1:0] ld_press;
    logic              chord_new;
    logic              chord_old;
    logic              emit;
    logic              is_last;
    logic [NUM_EV-1:0] rest;

    always_comb begin
        diff      = i_apply.data ^ r_bits;
        chord_new = (i_apply.data & CHORD_MASK) == CHORD_MASK;
        chord_old = (r_bits & CHORD_MASK) == CHORD_MASK;
        ld_pend[0]  = chord_new ^ chord_old;
        ld_press[0] = chord_new;
        for (int k = 0; k < BTN_W; k++) begin
            ld_pend[k+1]  = diff[KEY_BIT[k]];
            ld_press[k+1] = i_apply.data[KEY_BIT[k]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SCAN_IDLE;
            r_bits  <= '0;
            r_pend  <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_idx   <= n_idx;
            r_ov    <= n_ov;
            if (i_load && i_apply.en) begin
                r_bits <= i_apply.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_press <= ld_press;
        end
        if (emit) begin
            r_key     <= r_idx;
            r_pressed <= r_press[r_idx];
            r_last    <= is_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        n_idx   = r_idx;
        n_ov    = r_ov && !o_event.ready;
        emit    = 1'b0;
        rest    = r_pend;
        rest[r_idx] = 1'b0;
        is_last = (rest == '0);

        unique case (r_state)
            SCAN_IDLE: begin
                if (i_load && i_apply.en) begin
                    n_pend = ld_pend;
                    n_idx  = '0;
                    if (ld_pend != '0) begin
                        n_state = SCAN_RUN;
                    end
                end
            end
            SCAN_RUN: begin
                if (r_pend[r_idx]) begin
                    if (!r_ov || o_event.ready) begin
                        emit   = 1'b1;
                        n_ov   = 1'b1;
                        n_pend = rest;
                        n_idx  = r_idx + 1'b1;
                        if (is_last) begin
                            n_state = SCAN_IDLE;
                        end
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: n_state = SCAN_IDLE;
        endcase
    end

    assign o_busy          = (r_state != SCAN_IDLE);
    assign o_event.valid   = r_ov;
    assign o_event.key     = r_key;
    assign o_event.pressed = r_pressed;
    assign o_event.last    = r_last;

endmodule

>>> hdl/wireless_pad_key_event_generator_unit.sv
`timescale 1ns / 1ps

// Wireless pad key event generator. Each poll beat on i_poll steps the link
// state machine and the idle poll counter; when button data applies, a small
// sequencer walks the eleven events (escape, then A, B, L, R, start, select,
// up, down, left, right) one per cycle while o_event does not stall, and sends
// a beat on o_event for each one that changed, the final one flagged last.
// i_poll is not ready while the walk runs. The registered output lets the next
// poll be taken while the final event still waits. Configuration writes land
// at once and are to be made while idle; the block does not enforce this.

module wireless_pad_key_event_generator_unit
    import wpkeg_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    wpkeg_poll_if.sink            i_poll,
    wpkeg_event_if.source         o_event
);

    logic   accept;
    logic   busy;
    t_apply apply;

    assign i_poll.ready = !busy;
    assign accept       = i_poll.valid && !busy;

    wpkeg_link #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_link (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (accept),
        .i_payload_ready (i_poll.payload_ready),
        .i_first_byte    (i_poll.first_byte),
        .i_second_byte   (i_poll.second_byte),
        .o_apply         (apply)
    );

    wpkeg_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_apply (apply),
        .o_busy  (busy),
        .o_event (o_event)
    );

endmodule

>>> dv/wpkeg_key_event_checker.sv
`timescale 1ns / 1ps

module wpkeg_key_event_checker
    import wpkeg_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    wpkeg_poll_if                 i_poll,
    wpkeg_event_if                i_event,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             pressed;
        logic             last;
    } key_event_t;

    localparam logic [KEY_W-1:0] KEY_ESCAPE = '0;

    // button bit for A, B, L, R, start, select, up, down, left, right
    localparam logic [BTN_W-1:0] BUTTON_MASK [BTN_W] = '{
        10'h001, 10'h002, 10'h100, 10'h200, 10'h080,
        10'h040, 10'h010, 10'h020, 10'h008, 10'h004
    };

    key_event_t             due_events [$];
    t_link                  link_q;
    logic [COUNT_WIDTH-1:0] idle_polls_q;
    logic [BTN_W-1:0]       buttons_q;
    logic [TIMEOUT_W-1:0]   timeout_q;
    logic [MARKER_W-1:0]    marker_q;

    task automatic walk_buttons(input logic [BTN_W-1:0] data);
        key_event_t       batch [$];
        logic             chord_new;
        logic             chord_old;
        logic [BTN_W-1:0] m;
        int               i;
        chord_new = (data & CHORD_MASK) == CHORD_MASK;
        chord_old = (buttons_q & CHORD_MASK) == CHORD_MASK;
        if (chord_new && !chord_old) begin
            batch.push_back(key_event_t'{KEY_ESCAPE, 1'b1, 1'b0});
        end
        if (!chord_new && chord_old) begin
            batch.push_back(key_event_t'{KEY_ESCAPE, 1'b0, 1'b0});
        end
        for (i = 0; i < BTN_W; i++) begin
            m = BUTTON_MASK[i];
            if ((data & m) != (buttons_q & m)) begin
                buttons_q = (buttons_q & ~m) | (data & m);
                batch.push_back(key_event_t'{KEY_W'(i + 1), |(data & m), 1'b0});
            end
        end
        if (batch.size() > 0) begin
            batch[batch.size() - 1].last = 1'b1;
        end
        foreach (batch[j]) begin
            due_events.push_back(batch[j]);
        end
    endtask

    task automatic predict_poll(input logic rdy, input logic [7:0] b0, input logic [7:0] b1);
        logic have_data;
        have_data = rdy;
        if (link_q == LINK_UNKNOWN) begin
            link_q = LINK_SEARCHING;
        end
        if (link_q == LINK_SEARCHING && have_data) begin
            idle_polls_q = '0;
            link_q       = (b1 == marker_q) ? LINK_EIGHT : LINK_TEN;
            have_data    = 1'b0;
        end
        if (link_q == LINK_TEN || link_q == LINK_EIGHT) begin
            if (idle_polls_q >= timeout_q) begin
                link_q = LINK_UNKNOWN;
            end else if (have_data) begin
                idle_polls_q = '0;
                if (link_q == LINK_TEN) begin
                    walk_buttons({b0[1:0], b1});
                end else begin
                    walk_buttons({2'b00, b0});
                end
            end
        end else begin
            walk_buttons('0);
        end
        if (idle_polls_q != '1) begin
            idle_polls_q = idle_polls_q + 1'b1;
        end
    endtask

    task automatic check_event();
        key_event_t want;
        if (due_events.size() == 0) begin
            $display("%0t: unexpected event key %0d pressed %0d last %0d", $time,
                     i_event.key, i_event.pressed, i_event.last);
            o_fail_count++;
        end else begin
            want = due_events.pop_front();
            if (i_event.key !== want.key) begin
                $display("%0t: key expected %0d got %0d", $time, want.key, i_event.key);
                o_fail_count++;
            end
            if (i_event.pressed !== want.pressed) begin
                $display("%0t: pressed expected %0d got %0d", $time, want.pressed,
                         i_event.pressed);
                o_fail_count++;
            end
            if (i_event.last !== want.last) begin
                $display("%0t: last expected %0d got %0d", $time, want.last, i_event.last);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            link_q       = LINK_UNKNOWN;
            idle_polls_q = '0;
            buttons_q    = '0;
            timeout_q    = TIMEOUT_RST;
            marker_q     = MARKER_RST;
            o_fail_count = 0;
            due_events.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TIMEOUT: timeout_q = i_cfg_data[TIMEOUT_W-1:0];
                    CFG_MARKER:  marker_q  = i_cfg_data[MARKER_W-1:0];
                    default: ;
                endcase
            end
            if (i_event.valid && i_event.ready) begin
                check_event();
            end
            if (i_poll.valid && i_poll.ready) begin
                predict_poll(i_poll.payload_ready, i_poll.first_byte, i_poll.second_byte);
            end
        end
        o_pending = due_events.size();
    end

endmodule

>>> dv/wireless_pad_key_event_generator_unit_tb.sv
`timescale 1ns / 1ps

module wireless_pad_key_event_generator_unit_tb;
    import wpkeg_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    bit                    idling_on;
    int                    hold_cycles;

    wpkeg_poll_if  poll_ch ();
    wpkeg_event_if event_ch ();

    wireless_pad_key_event_generator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_poll     (poll_ch),
        .o_event    (event_ch)
    );

    wpkeg_key_event_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_poll       (poll_ch),
        .i_event      (event_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // event sink: random back-pressure, plus a counted hold-off on request
    initial begin
        event_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                event_ch.ready <= 1'b0;
                hold_cycles--;
            end else begin
                event_ch.ready <= !(idling_on && $urandom_range(0, 99) < 24);
            end
        end
    end

    task automatic send_poll(input logic rdy, input logic [7:0] b0, input logic [7:0] b1);
        while (idling_on && $urandom_range(0, 99) < 24) begin
            poll_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        poll_ch.valid         <= 1'b1;
        poll_ch.payload_ready <= rdy;
        poll_ch.first_byte    <= b0;
        poll_ch.second_byte   <= b1;
        do @(posedge i_clk); while (!poll_ch.ready);
    endtask

    // drop valid and wait until every due event has been seen, then let the walk finish
    task automatic drain();
        poll_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic configure(input logic [TIMEOUT_W-1:0] timeout, input logic [MARKER_W-1:0] marker);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_TIMEOUT;
        cfg_data <= timeout;
        @(posedge i_clk);
        cfg_idx  <= CFG_MARKER;
        cfg_data <= CFG_DATA_W'(marker);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        logic                 rdy;
        logic [7:0]           b0;
        logic [7:0]           b1;
        logic [MARKER_W-1:0]  marker;
        logic [TIMEOUT_W-1:0] timeout;
        int                   pick;

        poll_ch.valid         = 1'b0;
        poll_ch.payload_ready = 1'b0;
        poll_ch.first_byte    = '0;
        poll_ch.second_byte   = '0;
        cfg_we                = 1'b0;
        cfg_idx               = CFG_TIMEOUT;
        cfg_data              = '0;
        i_rst_n               = 1'b0;
        idling_on             = 1'b1;
        hold_cycles           = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: eight-button pad detect and data
        send_poll(1'b0, 8'h00, 8'h00);
        send_poll(1'b1, 8'h12, MARKER_RST);
        send_poll(1'b1, 8'hFF, 8'h00);
        send_poll(1'b1, 8'h00, 8'hFF);
        send_poll(1'b1, 8'hA5, 8'h5A);
        drain();

        // short timeout: lose the pad, release on searching, then ten-button pad
        configure(16'd3, 8'h00);
        repeat (4) send_poll(1'b0, 8'hFF, 8'hFF);
        send_poll(1'b1, 8'h33, 8'h01);
        send_poll(1'b1, 8'h03, 8'hC3);
        send_poll(1'b1, 8'hFF, 8'hFF);
        send_poll(1'b1, 8'h00, 8'h00);
        send_poll(1'b1, 8'h02, 8'h41);
        repeat (2) send_poll(1'b0, 8'h00, 8'h00);
        send_poll(1'b1, 8'hFF, 8'hFF);
        send_poll(1'b0, 8'h00, 8'h00);
        drain();

        // zero timeout: drop straight after detection
        configure(16'd0, 8'hFF);
        send_poll(1'b1, 8'h00, 8'hFF);
        send_poll(1'b1, 8'h77, 8'h10);
        send_poll(1'b0, 8'h00, 8'h00);
        drain();

        // widest timeout: hold the pad through a run of empty polls
        idling_on = 1'b0;
        configure(16'hFFFF, MARKER_RST);
        send_poll(1'b1, 8'h00, MARKER_RST);
        send_poll(1'b1, 8'h0F, 8'h00);
        repeat (20) send_poll(1'b0, 8'($urandom), 8'($urandom));
        send_poll(1'b0, 8'h00, 8'h00);
        drain();
        idling_on = 1'b1;

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    timeout = 16'($urandom_range(2, 6));
                    marker  = 8'($urandom);
                end
                1: begin
                    timeout = 16'($urandom_range(20, 400));
                    marker  = 8'h00;
                end
                2: begin
                    timeout = 16'($urandom_range(8, 20));
                    marker  = 8'hFF;
                end
                default: begin
                    timeout = 16'd1;
                    marker  = 8'($urandom);
                end
            endcase
            drain();
            configure(timeout, marker);
            for (int k = 0; k < 55; k++) begin
                if (p == 1 && k == 0) idling_on = 1'b0;
                if (p == 1 && k == 50) idling_on = 1'b1;
                if (p == 0 && k == 20) begin
                    hold_cycles = 300;
                    send_poll(1'b1, 8'($urandom), marker ^ 8'h01);
                    repeat (7) begin
                        send_poll(1'b1, 8'hFF, 8'hFF);
                        send_poll(1'b1, 8'h00, 8'h00);
                    end
                end
                if (k == 35) begin
                    poll_ch.valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                rdy  = $urandom_range(0, 99) < 75;
                b0   = 8'($urandom);
                b1   = 8'($urandom);
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    b0 = b0 | 8'h03;
                    b1 = b1 | 8'hC3;
                end else if (pick < 6) begin
                    b1 = marker;
                end else if (pick == 6) begin
                    b0 = 8'h00;
                    b1 = 8'h00;
                end
                send_poll(rdy, b0, b1);
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
